// ----- rtl/core/sit_pkg.sv -----
// Shared constants for the segment intersection test pipeline.
// Used by segment_intersection_test_unit, sit_mul, the checker and the testbench; no dependencies.
`default_nettype none

package sit_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int EPS_WIDTH   = 16;
  localparam int EPS_RESET   = 1;
  localparam int LIMB_WIDTH  = 32;
  // ratio lanes: first x, first y, second x, second y
  localparam int NUM_LANES   = 4;

endpackage

`default_nettype wire

// ----- rtl/core/segment_intersection_test_unit.sv -----
// Two-segment intersection test: fixed-point line solve, divide and bounds checks.
// Uses sit_pkg, sit_mul, sit_delay and sit_div.
//
// Input channel seg_valid/seg_stall carries one segment pair and strict_bounds per
// transfer; output channel hit_valid/hit_stall returns one result per pair.
// epsilon_we writes epsilon_wdata into the tolerance register in the same cycle;
// write it only while no pair is in flight.
// Throughput: one pair per cycle while seg_stall is low. The quotient divider, one
// bit per stage, sets the pipeline depth. All stages advance together.
// Output register plus one skid entry: while hit_stall holds a result the pipeline
// keeps moving until the next result reaches its end; that result is parked in the
// skid, then seg_stall rises and all stages hold until the output drains.
// Reset (rst, synchronous) empties the pipeline and sets epsilon to one.
// When lines_meet is low, cross_x, cross_y and segments_cross read zero.
`default_nettype none

module segment_intersection_test_unit #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = sit_pkg::FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          epsilon_we,
  input  logic [sit_pkg::EPS_WIDTH-1:0] epsilon_wdata,
  input  logic                          seg_valid,
  output logic                          seg_stall,
  input  logic signed [COORD_WIDTH-1:0] first_start_x,
  input  logic signed [COORD_WIDTH-1:0] first_start_y,
  input  logic signed [COORD_WIDTH-1:0] first_end_x,
  input  logic signed [COORD_WIDTH-1:0] first_end_y,
  input  logic signed [COORD_WIDTH-1:0] second_start_x,
  input  logic signed [COORD_WIDTH-1:0] second_start_y,
  input  logic signed [COORD_WIDTH-1:0] second_end_x,
  input  logic signed [COORD_WIDTH-1:0] second_end_y,
  input  logic                          strict_bounds,
  output logic                          hit_valid,
  input  logic                          hit_stall,
  output logic                          segments_cross,
  output logic                          lines_meet,
  output logic signed [COORD_WIDTH-1:0] cross_x,
  output logic signed [COORD_WIDTH-1:0] cross_y
);

  import sit_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int E    = EPS_WIDTH;
  localparam int NL   = NUM_LANES;
  localparam int AW   = W + 1;
  localparam int CW   = 2 * W + 1;
  localparam int DTW  = 2 * W + 3;
  localparam int NXW  = 3 * W + 3;
  localparam int UW   = 3 * W + 4;
  localparam int VW   = 3 * W + 4;
  localparam int EVW  = VW + E + 1;
  localparam int LMW  = DTW + E + 2;
  localparam int KW   = VW + F + E + 2;
  localparam int LAT  = W + 16;
  localparam int LAST = LAT - 1;

  // ---------------- control ----------------
  logic [E-1:0]        eps;
  logic signed [E:0]   eps_x;
  logic signed [E+1:0] eps_a;
  logic signed [E+F+1:0] epsf;
  logic                en;
  logic [LAT-1:0]      vld;
  logic                skid_valid;
  logic                take;

  assign eps_x = $signed({1'b0, eps});
  assign eps_a = $signed({2'b00, eps});
  assign epsf  = $signed({2'b00, eps, {F{1'b0}}});
  assign en        = !skid_valid;
  assign seg_stall = skid_valid;
  assign take      = hit_valid && !hit_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= E'(EPS_RESET);
    end else if (epsilon_we) begin
      eps <= epsilon_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], seg_valid};
    end
  end

  // ---------------- stage 0: input register ----------------
  logic signed [W-1:0] fsx_s0, fsy_s0, fex_s0, fey_s0;
  logic signed [W-1:0] ssx_s0, ssy_s0, sex_s0, sey_s0;
  logic                strict_s0;

  always_ff @(posedge clk) begin
    if (en) begin
      fsx_s0    <= first_start_x;
      fsy_s0    <= first_start_y;
      fex_s0    <= first_end_x;
      fey_s0    <= first_end_y;
      ssx_s0    <= second_start_x;
      ssy_s0    <= second_start_y;
      sex_s0    <= second_end_x;
      sey_s0    <= second_end_y;
      strict_s0 <= strict_bounds;
    end
  end

  // ---------------- stage 1: line coefficients ----------------
  logic signed [W-1:0]  fsx_s1, fsy_s1, fex_s1, fey_s1;
  logic signed [W-1:0]  ssx_s1, ssy_s1, sex_s1, sey_s1;
  logic signed [AW-1:0] fa_s1, fb_s1, fdx_s1, sa_s1, sb_s1, sdx_s1;
  logic signed [AW-1:0] span_s1 [NL];

  always_ff @(posedge clk) begin
    if (en) begin
      fsx_s1 <= fsx_s0;
      fsy_s1 <= fsy_s0;
      fex_s1 <= fex_s0;
      fey_s1 <= fey_s0;
      ssx_s1 <= ssx_s0;
      ssy_s1 <= ssy_s0;
      sex_s1 <= sex_s0;
      sey_s1 <= sey_s0;
      fa_s1  <= AW'(fey_s0) - AW'(fsy_s0);
      fb_s1  <= AW'(fsx_s0) - AW'(fex_s0);
      fdx_s1 <= AW'(fex_s0) - AW'(fsx_s0);
      sa_s1  <= AW'(sey_s0) - AW'(ssy_s0);
      sb_s1  <= AW'(ssx_s0) - AW'(sex_s0);
      sdx_s1 <= AW'(sex_s0) - AW'(ssx_s0);
    end
  end

  always_comb begin
    span_s1[0] = fdx_s1;
    span_s1[1] = fa_s1;
    span_s1[2] = sdx_s1;
    span_s1[3] = sa_s1;
  end

  // stage 2: short-span flags per lane
  logic [NL-1:0] flat_s2, flat_s19;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NL; k++) begin
        flat_s2[k] <= (span_s1[k] < eps_a) && (span_s1[k] > -eps_a);
      end
    end
  end

  sit_delay #(.WIDTH(NL), .DEPTH(17)) u_dl_flat (
    .clk(clk), .en(en), .d(flat_s2), .q(flat_s19)
  );

  // ---------------- stages 1..5: c terms and determinant products ----------
  logic signed [2*W-1:0]  p_fc0, p_fc1, p_sc0, p_sc1;
  logic signed [2*AW-1:0] p_d0, p_d1;

  sit_mul #(.AW(W), .BW(W)) u_m_fc0 (.clk(clk), .en(en), .a(fex_s1), .b(fsy_s1), .p(p_fc0));
  sit_mul #(.AW(W), .BW(W)) u_m_fc1 (.clk(clk), .en(en), .a(fey_s1), .b(fsx_s1), .p(p_fc1));
  sit_mul #(.AW(W), .BW(W)) u_m_sc0 (.clk(clk), .en(en), .a(sex_s1), .b(ssy_s1), .p(p_sc0));
  sit_mul #(.AW(W), .BW(W)) u_m_sc1 (.clk(clk), .en(en), .a(sey_s1), .b(ssx_s1), .p(p_sc1));
  sit_mul #(.AW(AW), .BW(AW)) u_m_d0 (.clk(clk), .en(en), .a(fa_s1), .b(sb_s1), .p(p_d0));
  sit_mul #(.AW(AW), .BW(AW)) u_m_d1 (.clk(clk), .en(en), .a(sa_s1), .b(fb_s1), .p(p_d1));

  localparam int D6W = 6 * AW + 4 * W;
  logic [D6W-1:0] dl6_d, dl6_q;
  logic signed [AW-1:0] fa_s6, fb_s6, sa_s6, sb_s6, fdx_s6, sdx_s6;
  logic signed [W-1:0]  fsx_s6, fsy_s6, ssx_s6, ssy_s6;

  assign dl6_d = {fa_s1, fb_s1, sa_s1, sb_s1, fdx_s1, sdx_s1,
                  fsx_s1, fsy_s1, ssx_s1, ssy_s1};
  assign {fa_s6, fb_s6, sa_s6, sb_s6, fdx_s6, sdx_s6,
          fsx_s6, fsy_s6, ssx_s6, ssy_s6} = dl6_q;

  sit_delay #(.WIDTH(D6W), .DEPTH(5)) u_dl_s6 (
    .clk(clk), .en(en), .d(dl6_d), .q(dl6_q)
  );

  // ---------------- stage 6: c1, c2, det ----------------
  logic signed [CW-1:0]  fc_s6, sc_s6;
  logic signed [DTW-1:0] det_s6;

  always_ff @(posedge clk) begin
    if (en) begin
      fc_s6  <= CW'(p_fc0) - CW'(p_fc1);
      sc_s6  <= CW'(p_sc0) - CW'(p_sc1);
      det_s6 <= DTW'(p_d0) - DTW'(p_d1);
    end
  end

  // stage 7: parallel test and |det|
  logic                  meet_s7, meet_l;
  logic signed [DTW:0]   adet_s7, adet_s13;

  always_ff @(posedge clk) begin
    if (en) begin
      meet_s7 <= !((det_s6 == '0) || ((det_s6 < epsf) && (det_s6 > -epsf)));
      adet_s7 <= det_s6[DTW-1] ? -((DTW+1)'(det_s6)) : (DTW+1)'(det_s6);
    end
  end

  sit_delay #(.WIDTH(1), .DEPTH(W + 8)) u_dl_meet (
    .clk(clk), .en(en), .d(meet_s7), .q(meet_l)
  );

  sit_delay #(.WIDTH(DTW + 1), .DEPTH(6)) u_dl_adet (
    .clk(clk), .en(en), .d(adet_s7), .q(adet_s13)
  );

  // ---------------- stages 6..10: numerators, s*det, det*span ----------
  logic signed [AW+CW-1:0]  p_n0, p_n1, p_n2, p_n3;
  logic signed [W-1:0]      st_s6 [NL];
  logic signed [AW-1:0]     sp_s6 [NL];
  logic signed [W+DTW-1:0]  p_sd [NL];
  logic signed [VW-1:0]     p_v  [NL];

  always_comb begin
    st_s6[0] = fsx_s6;
    st_s6[1] = fsy_s6;
    st_s6[2] = ssx_s6;
    st_s6[3] = ssy_s6;
    sp_s6[0] = fdx_s6;
    sp_s6[1] = fa_s6;
    sp_s6[2] = sdx_s6;
    sp_s6[3] = sa_s6;
  end

  sit_mul #(.AW(AW), .BW(CW)) u_m_n0 (.clk(clk), .en(en), .a(fb_s6), .b(sc_s6), .p(p_n0));
  sit_mul #(.AW(AW), .BW(CW)) u_m_n1 (.clk(clk), .en(en), .a(sb_s6), .b(fc_s6), .p(p_n1));
  sit_mul #(.AW(AW), .BW(CW)) u_m_n2 (.clk(clk), .en(en), .a(sa_s6), .b(fc_s6), .p(p_n2));
  sit_mul #(.AW(AW), .BW(CW)) u_m_n3 (.clk(clk), .en(en), .a(fa_s6), .b(sc_s6), .p(p_n3));

  for (genvar k = 0; k < NL; k++) begin : g_lane_a
    sit_mul #(.AW(W), .BW(DTW)) u_m_sd (
      .clk(clk), .en(en), .a(st_s6[k]), .b(det_s6), .p(p_sd[k])
    );
    sit_mul #(.AW(DTW), .BW(AW)) u_m_v (
      .clk(clk), .en(en), .a(det_s6), .b(sp_s6[k]), .p(p_v[k])
    );
  end

  logic [DTW-1:0] det_q11;
  logic signed [DTW-1:0] det_s11;

  sit_delay #(.WIDTH(DTW), .DEPTH(5)) u_dl_det (
    .clk(clk), .en(en), .d(det_s6), .q(det_q11)
  );
  assign det_s11 = $signed(det_q11);

  // ---------------- stages 11..13: u terms and sign normalization ----------
  logic signed [NXW-1:0]   nx_s11, ny_s11;
  logic signed [W+DTW-1:0] sd_s11 [NL];
  logic signed [VW-1:0]    v_s11  [NL];
  logic signed [UW-1:0]    u_s12  [NL];
  logic signed [VW-1:0]    v_s12  [NL];
  logic signed [UW-1:0]    un_s13 [NL];
  logic signed [VW-1:0]    vn_s13 [NL];
  logic signed [UW:0]      au_s13 [NL];

  always_ff @(posedge clk) begin
    if (en) begin
      nx_s11 <= NXW'(p_n0) - NXW'(p_n1);
      ny_s11 <= NXW'(p_n2) - NXW'(p_n3);
      for (int k = 0; k < NL; k++) begin
        sd_s11[k] <= p_sd[k];
        v_s11[k]  <= p_v[k];
        u_s12[k]  <= (k % 2 == 0) ? UW'(nx_s11) - UW'(sd_s11[k])
                                  : UW'(ny_s11) - UW'(sd_s11[k]);
        v_s12[k]  <= v_s11[k];
        vn_s13[k] <= v_s12[k][VW-1] ? -v_s12[k] : v_s12[k];
        un_s13[k] <= v_s12[k][VW-1] ? -u_s12[k] : u_s12[k];
        au_s13[k] <= u_s12[k][UW-1] ? -((UW+1)'(u_s12[k])) : (UW+1)'(u_s12[k]);
      end
    end
  end

  // crossing point dividers
  logic signed [W-1:0] qx_l, qy_l;

  sit_div #(.NW(NXW), .DW(DTW), .QW(W)) u_div_x (
    .clk(clk), .en(en), .n(nx_s11), .d(det_s11), .q(qx_l)
  );
  sit_div #(.NW(NXW), .DW(DTW), .QW(W)) u_div_y (
    .clk(clk), .en(en), .n(ny_s11), .d(det_s11), .q(qy_l)
  );

  // ---------------- stages 13..17: epsilon products ----------------
  logic signed [EVW-1:0] p_ev [NL];
  logic signed [LMW-1:0] p_lim;
  logic signed [UW-1:0]  un_s17 [NL];
  logic signed [VW-1:0]  vn_s17 [NL];
  logic signed [UW:0]    au_s17 [NL];
  logic                  strict_s17, strict_s18;

  sit_mul #(.AW(DTW + 1), .BW(E + 1)) u_m_lim (
    .clk(clk), .en(en), .a(adet_s13), .b(eps_x), .p(p_lim)
  );

  for (genvar k = 0; k < NL; k++) begin : g_lane_b
    logic [2*UW+VW:0] ld_d, ld_q;
    sit_mul #(.AW(VW), .BW(E + 1)) u_m_ev (
      .clk(clk), .en(en), .a(vn_s13[k]), .b(eps_x), .p(p_ev[k])
    );
    assign ld_d = {un_s13[k], vn_s13[k], au_s13[k]};
    sit_delay #(.WIDTH(2 * UW + VW + 1), .DEPTH(4)) u_dl_lane (
      .clk(clk), .en(en), .d(ld_d), .q(ld_q)
    );
    assign {un_s17[k], vn_s17[k], au_s17[k]} = ld_q;
  end

  sit_delay #(.WIDTH(1), .DEPTH(17)) u_dl_strict (
    .clk(clk), .en(en), .d(strict_s0), .q(strict_s17)
  );

  // ---------------- stages 18..20: bounds compares ----------------
  logic signed [KW-1:0] u2_s18 [NL];
  logic signed [KW-1:0] lo_s18 [NL];
  logic signed [KW-1:0] hi_s18 [NL];
  logic [NL-1:0]        dg_s18, rk_s19;
  logic [1:0]           deg_s19, ok_s19;
  logic                 cross_s20, cross_l;

  always_ff @(posedge clk) begin
    if (en) begin
      strict_s18 <= strict_s17;
      for (int k = 0; k < NL; k++) begin
        u2_s18[k] <= KW'(un_s17[k]) <<< F;
        lo_s18[k] <= strict_s17 ? KW'(p_ev[k]) : '0;
        hi_s18[k] <= strict_s17 ? (KW'(vn_s17[k]) <<< F) - KW'(p_ev[k])
                                : (KW'(vn_s17[k]) <<< F);
        dg_s18[k] <= au_s17[k] < p_lim;
        rk_s19[k] <= (lo_s18[k] <= u2_s18[k]) && (u2_s18[k] <= hi_s18[k]);
      end
      deg_s19[0] <= !strict_s18 && dg_s18[0] && dg_s18[1];
      deg_s19[1] <= !strict_s18 && dg_s18[2] && dg_s18[3];
      cross_s20  <= ok_s19[0] && ok_s19[1];
    end
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      ok_s19[j] = (flat_s19[2*j] && flat_s19[2*j+1]) ? deg_s19[j]
                : ((flat_s19[2*j] || rk_s19[2*j]) && (flat_s19[2*j+1] || rk_s19[2*j+1]));
    end
  end

  sit_delay #(.WIDTH(1), .DEPTH(W - 5)) u_dl_cross (
    .clk(clk), .en(en), .d(cross_s20), .q(cross_l)
  );

  // ---------------- output register and skid ----------------
  logic                segments_cross_nx, lines_meet_nx;
  logic signed [W-1:0] cross_x_nx, cross_y_nx;
  logic                skid_cross, skid_meet;
  logic signed [W-1:0] skid_x, skid_y;

  assign segments_cross_nx = meet_l && cross_l;
  assign lines_meet_nx     = meet_l;
  assign cross_x_nx        = meet_l ? qx_l : '0;
  assign cross_y_nx        = meet_l ? qy_l : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (!hit_valid || take) begin
      hit_valid <= vld[LAST];
    end else if (vld[LAST]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        segments_cross <= skid_cross;
        lines_meet     <= skid_meet;
        cross_x        <= skid_x;
        cross_y        <= skid_y;
      end
    end else if (!hit_valid || take) begin
      segments_cross <= segments_cross_nx;
      lines_meet     <= lines_meet_nx;
      cross_x        <= cross_x_nx;
      cross_y        <= cross_y_nx;
    end else if (vld[LAST]) begin
      skid_cross <= segments_cross_nx;
      skid_meet  <= lines_meet_nx;
      skid_x     <= cross_x_nx;
      skid_y     <= cross_y_nx;
    end
  end

  // ---------------- checks ----------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> hit_valid)
    else $error("skid holds a result while output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(hit_valid && hit_stall && vld[LAST]))
    else $error("skid filled without a stalled output");

  a_parallel_zero: assert property (@(posedge clk) disable iff (rst)
    (hit_valid && !lines_meet) |-> (cross_x == '0 && cross_y == '0 && !segments_cross))
    else $error("parallel result carries a crossing");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !take) |=> $stable(vld))
    else $error("pipeline moved while skid was full");

endmodule

`default_nettype wire

// ----- rtl/core/sit_delay.sv -----
// Enabled shift line that carries side data alongside the arithmetic stages.
// Depends on nothing; DEPTH must be at least one.
`default_nettype none

module sit_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        tap[k] <= tap[k-1];
      end
    end
  end

  assign q = tap[DEPTH-1];

endmodule

`default_nettype wire

// ----- rtl/core/sit_mul.sv -----
// Pipelined signed multiplier built from 32x32 limb products.
// Stages: magnitude, limb products, column sum, sign restore. Uses sit_pkg.
`default_nettype none

module sit_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  import sit_pkg::*;

  localparam int L   = LIMB_WIDTH;
  localparam int NA  = (AW + L - 1) / L;
  localparam int NB  = (BW + L - 1) / L;
  localparam int PW  = AW + BW;
  localparam int ACW = (NA + NB) * L;

  logic [AW-1:0]     abs_a;
  logic [BW-1:0]     abs_b;
  logic [NA*L-1:0]   ma;
  logic [NB*L-1:0]   mb;
  logic              sgn1, sgn2, sgn3;
  logic [2*L-1:0]    pp [NA][NB];
  logic [ACW-1:0]    acc;
  logic [PW-1:0]     mag;

  assign abs_a = a[AW-1] ? $unsigned(-a) : $unsigned(a);
  assign abs_b = b[BW-1] ? $unsigned(-b) : $unsigned(b);

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (ACW'(pp[i][j]) << (L * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sgn1 <= a[AW-1] ^ b[BW-1];
      ma   <= (NA*L)'(abs_a);
      mb   <= (NB*L)'(abs_b);
      sgn2 <= sgn1;
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= ma[i*L +: L] * mb[j*L +: L];
        end
      end
      sgn3 <= sgn2;
      mag  <= acc[PW-1:0];
      p    <= sgn3 ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sit_div.sv -----
// Pipelined restoring divider: round-to-nearest signed quotient, saturated.
// One quotient bit per stage. Depends on nothing.
`default_nettype none

module sit_div #(
  parameter int NW = 99,
  parameter int DW = 67,
  parameter int QW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] n,
  input  logic signed [DW-1:0] d,
  output logic signed [QW-1:0] q
);

  localparam int RW = NW + 2;
  localparam int SW = DW + 1 + QW;
  localparam int XW = (RW > SW) ? RW : SW;
  localparam logic [QW-1:0] MAXP = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] MINN = {1'b1, {(QW-1){1'b0}}};

  logic [NW-1:0] an1;
  logic [DW-1:0] ad1;
  logic          sg1, sg2;
  logic [XW-1:0] rem2, dv2;

  logic [XW-1:0] rem_s [QW+1];
  logic [XW-1:0] dv_s  [QW+1];
  logic [QW-1:0] q_s   [QW+1];
  logic          sg_s  [QW+1];
  logic          ov_s  [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      an1      <= n[NW-1] ? $unsigned(-n) : $unsigned(n);
      ad1      <= d[DW-1] ? $unsigned(-d) : $unsigned(d);
      sg1      <= n[NW-1] ^ d[DW-1];
      // numerator 2|n| + |d|, divisor 2|d|
      rem2     <= XW'({an1, 1'b0}) + XW'(ad1);
      dv2      <= XW'({ad1, 1'b0});
      sg2      <= sg1;
      ov_s[0]  <= rem2 >= (dv2 << QW);
      rem_s[0] <= rem2;
      dv_s[0]  <= dv2;
      q_s[0]   <= '0;
      sg_s[0]  <= sg2;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_bit
    logic [XW-1:0] shd;
    logic          ge;
    assign shd = dv_s[k-1] << (QW - k);
    assign ge  = rem_s[k-1] >= shd;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k] <= ge ? rem_s[k-1] - shd : rem_s[k-1];
        dv_s[k]  <= dv_s[k-1];
        q_s[k]   <= {q_s[k-1][QW-2:0], ge};
        sg_s[k]  <= sg_s[k-1];
        ov_s[k]  <= ov_s[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (ov_s[QW]) begin
        q <= sg_s[QW] ? $signed(MINN) : $signed(MAXP);
      end else if (!sg_s[QW]) begin
        q <= (q_s[QW] > MAXP) ? $signed(MAXP) : $signed(q_s[QW]);
      end else begin
        q <= (q_s[QW] > MINN) ? $signed(MINN) : -$signed(q_s[QW]);
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/segment_intersection_checker.sv -----
// Checker for segment_intersection_test_unit: watches both channels and the epsilon port,
// predicts each segment pair's crossing result and compares it. Depends on sit_pkg.
`default_nettype none

module segment_intersection_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          epsilon_we,
  input  logic [sit_pkg::EPS_WIDTH-1:0] epsilon_wdata,
  input  logic                          seg_valid,
  input  logic                          seg_stall,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] first_start_x,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] first_start_y,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] first_end_x,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] first_end_y,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] second_start_x,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] second_start_y,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] second_end_x,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] second_end_y,
  input  logic                          strict_bounds,
  input  logic                          hit_valid,
  input  logic                          hit_stall,
  input  logic                          segments_cross,
  input  logic                          lines_meet,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] cross_x,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] cross_y,
  output int                            errors,
  output int                            pending
);
  import sit_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic   hit;
    logic   meet;
    coord_t px;
    coord_t py;
  } crossing_t;

  localparam wide_t UNIT = wide_t'(1) <<< FRAC_BITS;

  crossing_t expected_hits[$];
  wide_t     tol;

  function automatic wide_t mag(input wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic coord_t rounded_quotient(input wide_t n, input wide_t d);
    wide_t an, ad, q;
    wide_t hi_lim, lo_lim;
    an = mag(n);
    ad = mag(d);
    q = (an + an + ad) / (ad + ad);
    if ((n < 0) != (d < 0)) q = -q;
    hi_lim = (wide_t'(1) <<< (COORD_WIDTH - 1)) - 1;
    lo_lim = -(wide_t'(1) <<< (COORD_WIDTH - 1));
    if (q > hi_lim) q = hi_lim;
    if (q < lo_lim) q = lo_lim;
    return coord_t'(q);
  endfunction

  function automatic logic ratio_within(input wide_t u, input wide_t span, input wide_t det,
                                        input logic strict);
    wide_t v, uu, u2, lo, hi;
    v = det * span;
    uu = u;
    if (v < 0) begin
      v = -v;
      uu = -uu;
    end
    u2 = uu * UNIT;
    lo = strict ? tol * v : wide_t'(0);
    hi = strict ? (UNIT - tol) * v : UNIT * v;
    return (lo <= u2) && (u2 <= hi);
  endfunction

  function automatic logic lies_on(input wide_t sx, input wide_t sy, input wide_t ex,
                                   input wide_t ey, input wide_t nx, input wide_t ny,
                                   input wide_t det, input logic strict);
    wide_t dx, dy, ux, uy, lim;
    logic flatx, flaty;
    dx = ex - sx;
    dy = ey - sy;
    ux = nx - sx * det;
    uy = ny - sy * det;
    flatx = mag(dx) < tol;
    flaty = mag(dy) < tol;
    if (flatx && flaty) begin
      lim = tol * mag(det);
      return !strict && (mag(ux) < lim) && (mag(uy) < lim);
    end
    return (flatx || ratio_within(ux, dx, det, strict)) &&
           (flaty || ratio_within(uy, dy, det, strict));
  endfunction

  function automatic crossing_t solve_pair();
    wide_t s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y;
    wide_t a1, b1, c1, a2, b2, c2, det, nx, ny;
    crossing_t r;
    s1x = first_start_x;  s1y = first_start_y;
    e1x = first_end_x;    e1y = first_end_y;
    s2x = second_start_x; s2y = second_start_y;
    e2x = second_end_x;   e2y = second_end_y;
    a1 = e1y - s1y;  b1 = s1x - e1x;  c1 = e1x * s1y - e1y * s1x;
    a2 = e2y - s2y;  b2 = s2x - e2x;  c2 = e2x * s2y - e2y * s2x;
    det = a1 * b2 - a2 * b1;
    r = '0;
    if (det == 0 || mag(det) < tol * UNIT) return r;
    nx = b1 * c2 - b2 * c1;
    ny = c1 * a2 - c2 * a1;
    r.meet = 1'b1;
    r.px = rounded_quotient(nx, det);
    r.py = rounded_quotient(ny, det);
    r.hit = lies_on(s1x, s1y, e1x, e1y, nx, ny, det, strict_bounds) &&
            lies_on(s2x, s2y, e2x, e2y, nx, ny, det, strict_bounds);
    return r;
  endfunction

  always @(posedge clk) begin
    crossing_t want;
    if (rst) begin
      tol = wide_t'(EPS_RESET);
      expected_hits.delete();
      errors = 0;
    end else begin
      if (epsilon_we) tol = wide_t'(epsilon_wdata);
      if (seg_valid && !seg_stall) expected_hits.push_back(solve_pair());
      if (hit_valid && !hit_stall) begin
        if (expected_hits.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer: hit=%0b meet=%0b x=%h y=%h",
                                     segments_cross, lines_meet, cross_x, cross_y);
        end else begin
          want = expected_hits.pop_front();
          if (want.hit !== segments_cross || want.meet !== lines_meet ||
              want.px !== cross_x || want.py !== cross_y) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected hit=%0b meet=%0b x=%h y=%h, got hit=%0b meet=%0b x=%h y=%h",
                       want.hit, want.meet, want.px, want.py,
                       segments_cross, lines_meet, cross_x, cross_y);
          end
        end
      end
    end
    pending = expected_hits.size();
  end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Top of the segment_intersection_test_unit testbench: clock, reset, stimulus and verdict.
// Depends on sit_pkg, the RTL and segment_intersection_checker.
`default_nettype none

module testbench;
  import sit_pkg::*;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t ONE    = coord_t'(1) <<< FRAC_BITS;
  localparam coord_t CMAX   = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t CMIN   = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam int     DRAIN  = COORD_WIDTH + 40;
  localparam int     WD_MAX = 5000;
  localparam int     N_RAND = 1250;

  logic clk = 0;
  logic rst = 1;
  logic epsilon_we = 0;
  logic [EPS_WIDTH-1:0] epsilon_wdata = '0;
  logic seg_valid = 0;
  logic seg_stall;
  coord_t s1x = 0, s1y = 0, e1x = 0, e1y = 0, s2x = 0, s2y = 0, e2x = 0, e2y = 0;
  logic strict = 0;
  logic hit_valid;
  logic hit_stall = 0;
  logic segments_cross, lines_meet;
  coord_t cross_x, cross_y;
  int errors, pending;
  logic steady = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  segment_intersection_test_unit i_dut (
    .clk(clk), .rst(rst), .epsilon_we(epsilon_we), .epsilon_wdata(epsilon_wdata),
    .seg_valid(seg_valid), .seg_stall(seg_stall),
    .first_start_x(s1x), .first_start_y(s1y), .first_end_x(e1x), .first_end_y(e1y),
    .second_start_x(s2x), .second_start_y(s2y), .second_end_x(e2x), .second_end_y(e2y),
    .strict_bounds(strict), .hit_valid(hit_valid), .hit_stall(hit_stall),
    .segments_cross(segments_cross), .lines_meet(lines_meet),
    .cross_x(cross_x), .cross_y(cross_y)
  );

  segment_intersection_checker i_chk (
    .clk(clk), .rst(rst), .epsilon_we(epsilon_we), .epsilon_wdata(epsilon_wdata),
    .seg_valid(seg_valid), .seg_stall(seg_stall),
    .first_start_x(s1x), .first_start_y(s1y), .first_end_x(e1x), .first_end_y(e1y),
    .second_start_x(s2x), .second_start_y(s2y), .second_end_x(e2x), .second_end_y(e2y),
    .strict_bounds(strict), .hit_valid(hit_valid), .hit_stall(hit_stall),
    .segments_cross(segments_cross), .lines_meet(lines_meet),
    .cross_x(cross_x), .cross_y(cross_y), .errors(errors), .pending(pending)
  );

  always @(negedge clk) begin
    if (rst) hit_stall <= 1'b0;
    else hit_stall <= !steady && ($urandom_range(99) < 28);
  end

  always @(posedge clk) begin
    if (rst || (seg_valid && !seg_stall) || (hit_valid && !hit_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_MAX) begin
      $display("segment_intersection_test_unit verification failed");
      $finish;
    end
  end

  // called at a falling edge; returns at a falling edge after the transfer
  task automatic send_pair(input coord_t ax, input coord_t ay, input coord_t bx,
                           input coord_t by, input coord_t cx, input coord_t cy,
                           input coord_t dx, input coord_t dy, input logic st);
    while (!steady && $urandom_range(99) < 28) begin
      seg_valid <= 1'b0;
      @(negedge clk);
    end
    s1x <= ax; s1y <= ay; e1x <= bx; e1y <= by;
    s2x <= cx; s2y <= cy; e2x <= dx; e2y <= dy;
    strict <= st;
    seg_valid <= 1'b1;
    do @(posedge clk); while (seg_stall);
    @(negedge clk);
  endtask

  task automatic drain_and_set(input logic [EPS_WIDTH-1:0] eps);
    seg_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    epsilon_we <= 1'b1;
    epsilon_wdata <= eps;
    @(negedge clk);
    epsilon_we <= 1'b0;
  endtask

  function automatic coord_t near_coord(input int span_bits);
    return coord_t'($signed($urandom)) >>> (COORD_WIDTH - span_bits);
  endfunction

  task automatic random_pair();
    coord_t px, py, ux, uy, vx, vy;
    int unsigned mode;
    int sb;
    logic st;
    mode = $urandom_range(9);
    st = 1'($urandom_range(1));
    sb = $urandom_range(18, 24);
    px = near_coord(sb);
    py = near_coord(sb);
    ux = near_coord(sb);
    uy = near_coord(sb);
    vx = near_coord(sb);
    vy = near_coord(sb);
    case (mode)
      0, 1:
        send_pair($urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, st);
      2, 3, 4:
        send_pair(px - ux, py - uy, px + (ux >>> $urandom_range(3)), py + (uy >>> 1),
                  px - vx, py - vy, px + vx, py + (vy >>> $urandom_range(2)), st);
      5:
        send_pair(px, py, ux, uy, ux, uy, vx, vy, st);
      6:
        send_pair(px, py, px + ux, py + uy, px + (ux <<< 1), py + (uy <<< 1),
                  vx, vy, st);
      7:
        send_pair(px, py, px, py, px - vx, py - vy, px + vx, py + vy, st);
      8:
        send_pair(coord_t'($urandom_range(8)) * ONE - 4 * ONE,
                  coord_t'($urandom_range(8)) * ONE - 4 * ONE,
                  coord_t'($urandom_range(8)) * ONE - 4 * ONE,
                  coord_t'($urandom_range(8)) * ONE - 4 * ONE,
                  coord_t'($urandom_range(8)) * ONE - 4 * ONE,
                  coord_t'($urandom_range(8)) * ONE - 4 * ONE,
                  coord_t'($urandom_range(8)) * ONE - 4 * ONE,
                  coord_t'($urandom_range(8)) * ONE - 4 * ONE, st);
      default:
        send_pair(px, py, ux, uy, vx, vy, near_coord(32), near_coord(32), st);
    endcase
  endtask

  initial begin
    logic [EPS_WIDTH-1:0] eps_plan [6];
    eps_plan = '{16'd0, 16'hFFFF, 16'h8000, 16'd16, 16'h0100, 16'd1};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // plain X crossing, both strict settings
    send_pair(-ONE, -ONE, ONE, ONE, -ONE, ONE, ONE, -ONE, 1'b0);
    send_pair(-ONE, -ONE, ONE, ONE, -ONE, ONE, ONE, -ONE, 1'b1);
    // touching at an endpoint
    send_pair(0, 0, 2 * ONE, 0, 2 * ONE, 0, 2 * ONE, 2 * ONE, 1'b0);
    send_pair(0, 0, 2 * ONE, 0, 2 * ONE, 0, 2 * ONE, 2 * ONE, 1'b1);
    // lines meet outside the segments
    send_pair(0, 0, ONE, 0, 3 * ONE, -ONE, 3 * ONE, ONE, 1'b0);
    // parallel and collinear, all zero
    send_pair(0, 0, ONE, ONE, ONE, 0, 2 * ONE, ONE, 1'b0);
    send_pair(0, 0, ONE, 0, 2 * ONE, 0, 3 * ONE, 0, 1'b0);
    send_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
    // nearly parallel: determinant below the tolerance
    send_pair(0, 0, 1, 0, 0, 0, 1, 1, 1'b0);
    // point segment on the other segment
    send_pair(ONE, ONE, ONE, ONE, 0, 0, 2 * ONE, 2 * ONE, 1'b0);
    send_pair(ONE, ONE, ONE, ONE, 0, 0, 2 * ONE, 2 * ONE, 1'b1);
    // vertical and horizontal axes with zero span
    send_pair(ONE, -ONE, ONE, ONE, -ONE, 0, ONE, 0, 1'b0);
    // coordinate extremes and saturation of the crossing point
    send_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, 1'b0);
    send_pair(CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, 1'b1);
    send_pair(0, 0, ONE, 1, 0, ONE, ONE, ONE - 2, 1'b0);
    send_pair(0, 0, 1, 65535, CMAX, 0, CMAX, 1, 1'b0);
    send_pair(CMIN, 0, CMIN + 1, CMAX, CMAX, CMIN, CMAX - 1, CMAX, 1'b1);
    send_pair(-1, -1, -1, -1, -1, -1, 0, 0, 1'b0);

    for (int i = 0; i < N_RAND; i++) begin
      if (i % 200 == 0) drain_and_set(eps_plan[(i / 200) % 6]);
      steady <= (i >= 500 && i < 650);
      if (i == 900) begin
        seg_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      random_pair();
    end
    steady <= 1'b0;
    seg_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("segment_intersection_test_unit verification clean");
    end else begin
      $display("segment_intersection_test_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/sit_pkg.sv
rtl/core/sit_delay.sv
rtl/core/sit_mul.sv
rtl/core/sit_div.sv
rtl/core/segment_intersection_test_unit.sv
tb/segment_intersection_checker.sv
tb/testbench.sv
